// ===== hdl/pse_pkg.sv =====
// ----------------------------------------------------------------------------
// pse_pkg - shared types and constants for the product-except-self scan
// Vector capacity, derived index widths and the sequencer state type.
// ----------------------------------------------------------------------------
package pse_pkg;

   // vector capacity (2 .. 64)
   localparam int unsigned MAX_LEN = 64;
   localparam int unsigned ADDR_W  = $clog2(MAX_LEN);
   localparam int unsigned CNT_W   = $clog2(MAX_LEN + 1);
   localparam int unsigned ELEM_W  = 8;
   localparam int unsigned PROD_W  = 32;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [PROD_W-1:0]        prod_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,     // collecting elements
      ST_SUF_RD,   // first read of the suffix pass
      ST_SUF_PRE,  // prefix times suffix, written back
      ST_SUF_EL,   // suffix times element
      ST_EMIT      // results out in index order
   } state_type;

   // sign-extend one element to product width
   function automatic prod_type sext_elem(input elem_type e);
      return prod_type'(signed'(e));
   endfunction

endpackage

// ===== hdl/pse_if.sv =====
// ----------------------------------------------------------------------------
// pse_if - valid/ready channels of the product-except-self scan
// Element channel in, result channel out; a beat moves on valid and ready.
// ----------------------------------------------------------------------------
interface pse_req_if;
   import pse_pkg::*;

   logic     valid;
   logic     ready;
   elem_type value;
   logic     last_element;

   modport source (output valid, value, last_element, input ready);
   modport sink   (input valid, value, last_element, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;

   logic     valid;
   logic     ready;
   prod_type product;
   logic     last_result;
   logic     truncated;

   modport source (output valid, product, last_result, truncated, input ready);
   modport sink   (input valid, product, last_result, truncated, output ready);
endinterface

// ===== hdl/product_except_self_scan.sv =====
// ----------------------------------------------------------------------------
// product_except_self_scan - product of all other elements, no division
// Elements arrive one per beat on req_chan; a beat with last_element set
// closes the vector. Each stored element is kept with its exclusive prefix
// product. After the closing beat a suffix pass walks the vector from the
// top down, then one result per element leaves on rsp_chan in index order.
//
// Loading: req_chan.ready high while collecting, one element per beat.
// Suffix pass: both multiplies sharing one 32x32 unit.
// Emit pass: one result per cycle while rsp_chan.ready stays high.
// The first result follows the suffix pass, and req_chan.ready returns
// once the last result is loaded into the output register; the shared
// multiplier splits each element of the suffix pass into the ST_SUF_PRE
// and ST_SUF_EL steps.
// Elements beyond MAX_LEN are dropped; that run's results carry truncated.
// A stalled receiver holds the output register and pauses the emit pass;
// the last result may still wait while the next vector starts loading.
// Reset (synchronous) empties the vector and the output register; the
// element and prefix RAMs need no clearing.
// ----------------------------------------------------------------------------
module product_except_self_scan
   import pse_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   pse_req_if.sink       req_chan,
   pse_rsp_if.source     rsp_chan
);

   state_type state_ff, state_in;
   count_type count_ff, count_in;
   prod_type  running_ff, running_in;
   prod_type  suffix_ff, suffix_in;
   addr_type  idx_ff, idx_in;
   addr_type  last_idx_ff, last_idx_in;
   logic      single_ff, single_in;
   logic      overflow_ff, overflow_in;
   logic      rsp_valid_ff, rsp_valid_in;
   prod_type  rsp_product_ff, rsp_product_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      rsp_trunc_ff, rsp_trunc_in;

   logic      req_beat;
   logic      store_ok;
   count_type count_next;
   addr_type  rd_addr;
   logic      elem_we, pre_we;
   addr_type  wr_addr;
   prod_type  pre_wr_data;
   elem_type  elem_rd;
   prod_type  pre_rd;
   prod_type  mul_a, mul_b, mul_res;
   logic      can_load;

   // element and prefix stores
   pse_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (wr_addr),
      .wr_data (req_chan.value),
      .rd_addr (rd_addr),
      .rd_data (elem_rd)
   );

   pse_ram #(.WIDTH(PROD_W), .DEPTH(MAX_LEN)) u_pre_ram (
      .clock   (clock),
      .wr_en   (pre_we),
      .wr_addr (wr_addr),
      .wr_data (pre_wr_data),
      .rd_addr (rd_addr),
      .rd_data (pre_rd)
   );

   // the one multiplier
   pse_mul u_mul (
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res)
   );

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_beat       = req_chan.valid && (state_ff == ST_LOAD);
   assign store_ok       = (count_ff < count_type'(MAX_LEN));
   assign count_next     = count_ff + count_type'(store_ok);
   assign can_load       = !rsp_valid_ff || rsp_chan.ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         running_ff   <= prod_type'(1);
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      suffix_ff      <= suffix_in;
      idx_ff         <= idx_in;
      last_idx_ff    <= last_idx_in;
      single_ff      <= single_in;
      rsp_product_ff <= rsp_product_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_trunc_ff   <= rsp_trunc_in;
   end

   // sequencer: next state, unit operands, RAM control
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      running_in     = running_ff;
      suffix_in      = suffix_ff;
      idx_in         = idx_ff;
      last_idx_in    = last_idx_ff;
      single_in      = single_ff;
      overflow_in    = overflow_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_product_in = rsp_product_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_trunc_in   = rsp_trunc_ff;
      rd_addr        = idx_ff;
      elem_we        = 1'b0;
      pre_we         = 1'b0;
      wr_addr        = idx_ff;
      pre_wr_data    = mul_res;
      mul_a          = running_ff;
      mul_b          = sext_elem(req_chan.value);

      case (state_ff)
         ST_LOAD: begin
            // store the element with its exclusive prefix
            wr_addr     = count_ff[ADDR_W-1:0];
            pre_wr_data = running_ff;
            if (req_beat) begin
               if (store_ok) begin
                  elem_we    = 1'b1;
                  pre_we     = 1'b1;
                  running_in = mul_res;
                  count_in   = count_next;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_chan.last_element) begin
                  last_idx_in = addr_type'(count_next - count_type'(1));
                  idx_in      = addr_type'(count_next - count_type'(1));
                  single_in   = (count_next == count_type'(1));
                  suffix_in   = prod_type'(1);
                  state_in    = ST_SUF_RD;
               end
            end
         end
         ST_SUF_RD: begin
            state_in = ST_SUF_PRE;
         end
         ST_SUF_PRE: begin
            // result = prefix * suffix, written over the prefix
            mul_a    = pre_rd;
            mul_b    = suffix_ff;
            pre_we   = 1'b1;
            state_in = ST_SUF_EL;
         end
         ST_SUF_EL: begin
            // fold this element into the suffix, read the next one down
            mul_a     = suffix_ff;
            mul_b     = sext_elem(elem_rd);
            suffix_in = mul_res;
            if (idx_ff == '0) begin
               rd_addr  = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in   = idx_ff - addr_type'(1);
               rd_addr  = idx_ff - addr_type'(1);
               state_in = ST_SUF_PRE;
            end
         end
         ST_EMIT: begin
            // read data belongs to idx_ff; load output when it is free
            if (can_load) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = single_ff ? sext_elem(elem_rd) : pre_rd;
               rsp_last_in    = (idx_ff == last_idx_ff);
               rsp_trunc_in   = overflow_ff;
               if (idx_ff == last_idx_ff) begin
                  overflow_in = 1'b0;
                  running_in  = prod_type'(1);
                  count_in    = '0;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in  = idx_ff + addr_type'(1);
                  rd_addr = idx_ff + addr_type'(1);
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.product     = rsp_product_ff;
   assign rsp_chan.last_result = rsp_last_ff;
   assign rsp_chan.truncated   = rsp_trunc_ff;

   // ---- assertions ----
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_LEN))
      else $error("element count beyond capacity");

   a_empty_running_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && count_ff == '0) |-> running_ff == prod_type'(1))
      else $error("running product not one on an empty vector");

   a_close_starts_suffix: assert property (@(posedge clock) disable iff (reset)
      (req_beat && req_chan.last_element) |=> state_ff == ST_SUF_RD)
      else $error("closing beat did not start the suffix pass");

   a_emit_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> idx_ff <= last_idx_ff)
      else $error("emit index past the last element");

   a_run_ends_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT ##1 state_ff == ST_LOAD) |-> rsp_valid_ff && rsp_last_ff)
      else $error("emit pass ended without a last result");

endmodule

// ===== hdl/pse_ram.sv =====
// ----------------------------------------------------------------------------
// pse_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pse_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pse_mul.sv =====
// ----------------------------------------------------------------------------
// pse_mul - shared wrapping multiplier
// 32 x 32 multiply keeping the low 32 bits (two's complement wrap).
// ----------------------------------------------------------------------------
module pse_mul
   import pse_pkg::*;
(
   input  prod_type op_a,
   input  prod_type op_b,
   output prod_type result
);

   logic [2*PROD_W-1:0] full_prod;

   // low half is the same for signed and unsigned operands
   assign full_prod = {{PROD_W{1'b0}}, op_a} * {{PROD_W{1'b0}}, op_b};
   assign result    = full_prod[PROD_W-1:0];

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the product-except-self scan
// Vectors go in one element per beat with bursty, gapped valid; results
// are taken under a shifting ready pattern. A local predictor keeps the
// prefix products and builds each run's products of all other elements,
// and every result beat is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import pse_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES   = 3 * MAX_LEN + 8;
   localparam int unsigned RANDOM_ITEMS   = 28;
   localparam int unsigned MAX_REPORTS    = 10;

   typedef struct packed {
      prod_type product;
      logic     last_result;
      logic     truncated;
   } product_beat_type;

   // receiver ready patterns
   typedef enum logic [1:0] {
      RX_STREAM,   // ready held high
      RX_RANDOM,   // ready at random, half the time
      RX_SPARSE    // ready rarely, long stalls
   } rx_mode_type;

   logic clock;
   logic reset;

   pse_req_if req_chan ();
   pse_rsp_if rsp_chan ();

   product_except_self_scan i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   elem_type         stored_elems [MAX_LEN];
   prod_type         prefix_prods [MAX_LEN];
   prod_type         running_prod = 1;
   int unsigned      loaded_count = 0;
   logic             dropped_seen = 1'b0;
   product_beat_type pending_products [$];

   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;
   int unsigned burst_left     = 0;
   rx_mode_type rx_mode;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic prod_type widen_elem(input elem_type e);
      return {{(PROD_W - ELEM_W){e[ELEM_W-1]}}, e};
   endfunction

   // one element in; on the closing beat, queue the products of the run
   task automatic predict_products(input elem_type v, input logic closing);
      product_beat_type run_beats [MAX_LEN];
      prod_type         suffix;
      if (loaded_count < MAX_LEN) begin
         stored_elems[loaded_count] = v;
         prefix_prods[loaded_count] = running_prod;
         running_prod = running_prod * widen_elem(v);
         loaded_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (!closing) return;
      if (loaded_count == 1) begin
         // a lone element is echoed
         run_beats[0] = '{widen_elem(stored_elems[0]), 1'b1, dropped_seen};
      end else begin
         suffix = 1;
         for (int i = loaded_count - 1; i >= 0; i--) begin
            run_beats[i] = '{prefix_prods[i] * suffix, i == loaded_count - 1,
                             dropped_seen};
            suffix = suffix * widen_elem(stored_elems[i]);
         end
      end
      for (int i = 0; i < loaded_count; i++) pending_products.push_back(run_beats[i]);
      running_prod = 1;
      loaded_count = 0;
      dropped_seen = 1'b0;
   endtask

   task automatic check_product(input product_beat_type got);
      product_beat_type want;
      if (pending_products.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected result beat product=%0d last=%b trunc=%b",
                     $realtime, $signed(got.product), got.last_result, got.truncated);
         return;
      end
      want = pending_products.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch exp product=%0d last=%b trunc=%b, got product=%0d last=%b trunc=%b",
                     $realtime, $signed(want.product), want.last_result, want.truncated,
                     $signed(got.product), got.last_result, got.truncated);
      end
   endtask

   // beat monitor: predict on element beats, check on result beats
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_products(req_chan.value, req_chan.last_element);
         if (rsp_chan.valid && rsp_chan.ready)
            check_product('{rsp_chan.product, rsp_chan.last_result, rsp_chan.truncated});
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // watchdog on cycles without any beat
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: ready follows a pattern that changes after a random span
   initial begin
      int unsigned span;
      rsp_chan.ready = 1'b0;
      forever begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         span    = $urandom_range(10, 60);
         repeat (span) begin
            @(negedge clock);
            case (rx_mode)
               RX_STREAM: begin
                  rsp_chan.ready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_chan.ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_chan.ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   // one element beat; bursts of random length separated by short gaps
   task automatic send_element(input elem_type v, input logic closing);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                   : $urandom_range(1, 12);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.value        <= v;
      req_chan.last_element <= closing;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      burst_left--;
   endtask

   // element values: full range, extremes, small magnitudes and odd values
   function automatic elem_type pick_value();
      case ($urandom_range(0, 3))
         0: return elem_type'($urandom);
         1: begin
            case ($urandom_range(0, 4))
               0: return elem_type'(-128);
               1: return elem_type'(127);
               2: return elem_type'(-1);
               3: return elem_type'(0);
               default: return elem_type'(1);
            endcase
         end
         2: return elem_type'($signed($urandom_range(0, 6)) - 3);
         default: return elem_type'($urandom | 1);
      endcase
   endfunction

   // one-element vectors echo the element
   task automatic test_single_element();
      send_element(elem_type'(127), 1'b1);
      send_element(elem_type'(-128), 1'b1);
      send_element(elem_type'(0), 1'b1);
      send_element(elem_type'(-1), 1'b1);
   endtask

   // extremes of the element range, signs and zeros
   task automatic test_signs_and_zeros();
      send_element(elem_type'(127), 1'b0);
      send_element(elem_type'(-128), 1'b0);
      send_element(elem_type'(-1), 1'b0);
      send_element(elem_type'(1), 1'b1);
      send_element(elem_type'(-128), 1'b0);
      send_element(elem_type'(-128), 1'b1);
      // one zero: only its own slot is non-zero
      send_element(elem_type'(0), 1'b0);
      send_element(elem_type'(5), 1'b0);
      send_element(elem_type'(-3), 1'b1);
      // two zeros: every product is zero
      send_element(elem_type'(0), 1'b0);
      send_element(elem_type'(-7), 1'b0);
      send_element(elem_type'(0), 1'b1);
   endtask

   // products well past 32 bits wrap
   task automatic test_wrap();
      for (int i = 0; i < 6; i++)
         send_element((i % 2) ? elem_type'(-128) : elem_type'(127), i == 5);
   endtask

   // a full vector, then one that overflows and is closed by a dropped beat
   task automatic test_capacity();
      int unsigned extra;
      for (int i = 0; i < MAX_LEN; i++)
         send_element(elem_type'($urandom | 1), i == MAX_LEN - 1);
      extra = $urandom_range(1, 3);
      for (int i = 0; i < MAX_LEN + extra; i++)
         send_element((i < MAX_LEN) ? elem_type'($urandom | 1) : pick_value(),
                      i == MAX_LEN + extra - 1);
   endtask

   // random vectors, mostly short with the odd longer one
   task automatic test_random_vectors();
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) send_element(pick_value(), i == len - 1);
         sent += len;
      end
   endtask

   // main sequence
   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.value        = '0;
      req_chan.last_element = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_element();
      test_signs_and_zeros();
      test_wrap();
      test_capacity();
      test_random_vectors();
      req_chan.valid <= 1'b0;

      // wait out the outstanding results, then catch any strays
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_products.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
